// ----- src/bbfp_pkg.sv -----
package bbfp_pkg;

   localparam int BUF_BITS       = 4096;
   localparam int MAX_FIELD_BITS = 64;
   localparam int LEN_W          = 13;
   localparam int ADDR_W         = 12;
   localparam int CNT_W          = 7;
   localparam int VAL_W          = 32;
   localparam int FLD_W          = 64;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_INSERT = 3'd2,
      OP_TAIL   = 3'd3,
      OP_ERASE  = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_COUNT    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_MOVE,
      S_PUT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic start_move;
      logic move_step;
      logic start_put;
      logic put_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_move;
      logic need_put;
      logic move_done;
      logic put_done;
   } stat_type;

endpackage

// ----- src/bbfp_datapath.sv -----
module bbfp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bbfp_pkg::cmd_type                      cmd,
   output bbfp_pkg::stat_type                     stat,
   input  logic [2:0]                             req_type,
   input  logic [bbfp_pkg::VAL_W-1:0]             req_field_value,
   input  logic [bbfp_pkg::LEN_W-1:0]             req_bit_position,
   input  logic [bbfp_pkg::CNT_W-1:0]             req_bit_count,
   output logic [1:0]                             rsp_status,
   output logic [bbfp_pkg::VAL_W-1:0]             rsp_read_value,
   output logic [bbfp_pkg::LEN_W-1:0]             rsp_bit_length
);

   logic                           mem [bbfp_pkg::BUF_BITS];
   logic                           rdata_ff;

   logic [2:0]                     op_ff;
   logic [bbfp_pkg::VAL_W-1:0]     val_ff;
   logic [bbfp_pkg::LEN_W-1:0]     pos_ff;
   logic [bbfp_pkg::CNT_W-1:0]     cnt_ff;
   logic [bbfp_pkg::LEN_W-1:0]     fill_ff, fill_in;

   logic [bbfp_pkg::LEN_W-1:0]     src_ff;
   logic [bbfp_pkg::LEN_W-1:0]     rem_ff;
   logic                           pend_ff;
   logic [bbfp_pkg::LEN_W-1:0]     dst_ff;
   logic                           down_ff;
   logic                           rd_mode_ff;
   logic [bbfp_pkg::VAL_W-1:0]     rv_ff;

   logic [bbfp_pkg::LEN_W-1:0]     put_addr_ff;
   logic [bbfp_pkg::CNT_W-1:0]     put_rem_ff;
   logic [bbfp_pkg::FLD_W-1:0]     fld_ff;

   logic [1:0]                     rsp_status_ff;
   logic [bbfp_pkg::VAL_W-1:0]     rsp_value_ff;
   logic [bbfp_pkg::LEN_W-1:0]     rsp_len_ff;

   logic [bbfp_pkg::LEN_W:0]       fill_plus_cnt;
   logic [bbfp_pkg::LEN_W:0]       pos_plus_cnt;
   logic                           cnt_big;
   logic [1:0]                     chk;
   logic                           ok;
   logic                           is_add;
   logic                           cnt_nz;
   logic                           wen;
   logic [bbfp_pkg::ADDR_W-1:0]    waddr;
   logic                           wbit;
   logic [bbfp_pkg::CNT_W-1:0]     lsh;

   assign fill_plus_cnt = {1'b0, fill_ff} + (bbfp_pkg::LEN_W+1)'(cnt_ff);
   assign pos_plus_cnt  = {1'b0, pos_ff} + (bbfp_pkg::LEN_W+1)'(cnt_ff);
   assign cnt_big = cnt_ff > bbfp_pkg::CNT_W'(bbfp_pkg::MAX_FIELD_BITS);
   assign is_add  = (op_ff == bbfp_pkg::OP_APPEND) || (op_ff == bbfp_pkg::OP_INSERT);
   assign cnt_nz  = cnt_ff != '0;

   always_comb begin
      chk = bbfp_pkg::ST_OK;
      case (op_ff)
         bbfp_pkg::OP_APPEND, bbfp_pkg::OP_INSERT: begin
            if (cnt_big) chk = bbfp_pkg::ST_COUNT;
            else if (pos_ff > fill_ff) chk = bbfp_pkg::ST_RANGE;
            else if (fill_plus_cnt > (bbfp_pkg::LEN_W+1)'(bbfp_pkg::BUF_BITS))
               chk = bbfp_pkg::ST_OVERFLOW;
         end
         bbfp_pkg::OP_TAIL: begin
            if (bbfp_pkg::LEN_W'(cnt_ff) > fill_ff) chk = bbfp_pkg::ST_RANGE;
         end
         bbfp_pkg::OP_ERASE: begin
            if (cnt_nz && pos_plus_cnt > {1'b0, fill_ff}) chk = bbfp_pkg::ST_RANGE;
         end
         bbfp_pkg::OP_READ: begin
            if (cnt_big) chk = bbfp_pkg::ST_COUNT;
            else if (pos_plus_cnt > {1'b0, fill_ff}) chk = bbfp_pkg::ST_RANGE;
         end
         default: chk = bbfp_pkg::ST_OK;
      endcase
   end

   assign ok = chk == bbfp_pkg::ST_OK;

   always_comb begin
      stat.need_move = ok && cnt_nz &&
         ((is_add && fill_ff > pos_ff) ||
          (op_ff == bbfp_pkg::OP_ERASE && {1'b0, fill_ff} > pos_plus_cnt) ||
          (op_ff == bbfp_pkg::OP_READ));
      stat.need_put  = ok && cnt_nz && is_add;
      stat.move_done = (rem_ff == '0) && !pend_ff;
      stat.put_done  = put_rem_ff == '0;
   end

   always_comb begin
      fill_in = fill_ff;
      if (op_ff == bbfp_pkg::OP_CLEAR) fill_in = '0;
      else if (ok && is_add) fill_in = fill_plus_cnt[bbfp_pkg::LEN_W-1:0];
      else if (ok && (op_ff == bbfp_pkg::OP_TAIL || op_ff == bbfp_pkg::OP_ERASE))
         fill_in = fill_ff - bbfp_pkg::LEN_W'(cnt_ff);
   end

   // one write port shared by the tail move and the field write
   always_comb begin
      wen   = 1'b0;
      waddr = dst_ff[bbfp_pkg::ADDR_W-1:0];
      wbit  = rdata_ff;
      if (cmd.put_step && put_rem_ff != '0) begin
         wen   = 1'b1;
         waddr = put_addr_ff[bbfp_pkg::ADDR_W-1:0];
         wbit  = fld_ff[bbfp_pkg::FLD_W-1];
      end else if (cmd.move_step && pend_ff && !rd_mode_ff) begin
         wen = 1'b1;
      end
   end

   assign lsh = bbfp_pkg::CNT_W'(bbfp_pkg::FLD_W) - cnt_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[src_ff[bbfp_pkg::ADDR_W-1:0]];
      if (wen) mem[waddr] <= wbit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rem_ff  <= '0;
         pend_ff <= 1'b0;
         put_rem_ff <= '0;
      end else begin
         if (cmd.load) begin
            op_ff  <= req_type;
            val_ff <= req_field_value;
            pos_ff <= (req_type == bbfp_pkg::OP_APPEND) ? fill_ff : req_bit_position;
            cnt_ff <= req_bit_count;
            rv_ff  <= '0;
         end
         if (cmd.start_move) begin
            pend_ff    <= 1'b0;
            rd_mode_ff <= op_ff == bbfp_pkg::OP_READ;
            if (is_add) begin
               down_ff <= 1'b1;
               src_ff  <= fill_ff - 1'b1;
               rem_ff  <= fill_ff - pos_ff;
            end else if (op_ff == bbfp_pkg::OP_ERASE) begin
               down_ff <= 1'b0;
               src_ff  <= pos_plus_cnt[bbfp_pkg::LEN_W-1:0];
               rem_ff  <= fill_ff - pos_plus_cnt[bbfp_pkg::LEN_W-1:0];
            end else begin
               down_ff <= 1'b0;
               src_ff  <= pos_ff;
               rem_ff  <= bbfp_pkg::LEN_W'(cnt_ff);
            end
         end else if (cmd.move_step) begin
            pend_ff <= rem_ff != '0;
            if (rem_ff != '0) begin
               rem_ff <= rem_ff - 1'b1;
               src_ff <= down_ff ? src_ff - 1'b1 : src_ff + 1'b1;
               dst_ff <= down_ff ? src_ff + bbfp_pkg::LEN_W'(cnt_ff)
                                 : src_ff - bbfp_pkg::LEN_W'(cnt_ff);
            end
            if (pend_ff && rd_mode_ff) rv_ff <= {rv_ff[bbfp_pkg::VAL_W-2:0], rdata_ff};
         end
         if (cmd.start_put) begin
            put_addr_ff <= pos_ff;
            put_rem_ff  <= cnt_ff;
            fld_ff      <= bbfp_pkg::FLD_W'(val_ff) << lsh;
         end else if (cmd.put_step && put_rem_ff != '0) begin
            put_addr_ff <= put_addr_ff + 1'b1;
            put_rem_ff  <= put_rem_ff - 1'b1;
            fld_ff      <= {fld_ff[bbfp_pkg::FLD_W-2:0], 1'b0};
         end
         if (cmd.finish) fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= chk;
         rsp_value_ff  <= (ok && op_ff == bbfp_pkg::OP_READ) ? rv_ff : '0;
         rsp_len_ff    <= fill_in;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_bit_length = rsp_len_ff;

endmodule

// ----- src/bbfp_ctrl.sv -----
module bbfp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bbfp_pkg::stat_type  stat,
   output bbfp_pkg::cmd_type   cmd
);

   bbfp_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbfp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         bbfp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bbfp_pkg::S_EVAL;
            end
         end
         bbfp_pkg::S_EVAL: begin
            if (stat.need_move) begin
               cmd.start_move = 1'b1;
               state_in = bbfp_pkg::S_MOVE;
            end else if (stat.need_put) begin
               cmd.start_put = 1'b1;
               state_in = bbfp_pkg::S_PUT;
            end else begin
               state_in = bbfp_pkg::S_FINISH;
            end
         end
         bbfp_pkg::S_MOVE: begin
            cmd.move_step = 1'b1;
            if (stat.move_done) begin
               if (stat.need_put) begin
                  cmd.start_put = 1'b1;
                  state_in = bbfp_pkg::S_PUT;
               end else begin
                  state_in = bbfp_pkg::S_FINISH;
               end
            end
         end
         bbfp_pkg::S_PUT: begin
            cmd.put_step = 1'b1;
            if (stat.put_done) state_in = bbfp_pkg::S_FINISH;
         end
         bbfp_pkg::S_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bbfp_pkg::S_IDLE;
            end
         end
         default: state_in = bbfp_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("response raised without finish");
   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == bbfp_pkg::S_EVAL)
      else $error("accepted request not evaluated");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.move_step && cmd.put_step) && !(cmd.finish && req_ready))
      else $error("datapath commands overlap");
`endif

endmodule

// ----- src/bit_buffer_field_pack_unpack.sv -----
// Bit buffer of up to 4096 bits with field append, insert, erase, tail drop and
// read. One request is handled at a time and answered by exactly one response;
// a new request is taken while the previous response still waits. A request
// passes from its accept through an evaluate state and a finish state back to
// ready. A tail move (the bits above the insert point for insert, the bits
// above the erased range for erase) or a read adds a move state, and the field
// write of append and insert adds a put state. The finish state waits while the
// previous response has not been taken. The single-bit buffer memory moves one
// bit per cycle, so an insert near the start is the worst case.
module bit_buffer_field_pack_unpack (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_type,
   input  logic [bbfp_pkg::VAL_W-1:0]        req_field_value,
   input  logic [bbfp_pkg::LEN_W-1:0]        req_bit_position,
   input  logic [bbfp_pkg::CNT_W-1:0]        req_bit_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [bbfp_pkg::VAL_W-1:0]        rsp_read_value,
   output logic [bbfp_pkg::LEN_W-1:0]        rsp_bit_length
);

   bbfp_pkg::cmd_type  cmd;
   bbfp_pkg::stat_type stat;

   bbfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bbfp_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_field_value  (req_field_value),
      .req_bit_position (req_bit_position),
      .req_bit_count    (req_bit_count),
      .rsp_status       (rsp_status),
      .rsp_read_value   (rsp_read_value),
      .rsp_bit_length   (rsp_bit_length)
   );

endmodule
